/* rtl/nhqw_pkg.sv */
package nhqw_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int ID_BYTES      = 8;
   localparam int ID_W          = 8 * ID_BYTES;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // field widths
   localparam int NODE_ID_W = 64;
   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 20;
   localparam int QUIET_W   = 20;
   localparam int REM_W     = PERIOD_W + 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30000);

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_HELLO_PERIOD = '0;

   // request codes
   localparam logic REQ_HELLO = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [NODE_ID_W-1:0] node_id;
      logic [TIME_W-1:0]    now_ms;
   } nhqw_req_type;

   typedef struct packed {
      logic [QUIET_W-1:0] quiet_ms;
      logic               known;
   } nhqw_rsp_type;

   // quiet window unit handshake
   typedef struct packed {
      logic                start;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   elapsed;
   } nhqw_calc_req_type;

   typedef struct packed {
      logic               done;
      logic [QUIET_W-1:0] quiet;
   } nhqw_calc_rsp_type;

endpackage

/* rtl/nhqw_quiet_calc.sv */
module nhqw_quiet_calc
   import nhqw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  nhqw_calc_req_type calc_req,
   output nhqw_calc_rsp_type calc_rsp
);

   logic                busy_ff, busy_in;
   logic                stale_ff, stale_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [PERIOD_W-1:0] per_ff, per_in;
   logic [REM_W-1:0]    triple;
   logic                fin;
   logic [REM_W-1:0]    half;

   assign triple = REM_W'(calc_req.period) + REM_W'({calc_req.period, 1'b0});
   assign fin    = stale_ff || (rem_ff < REM_W'(per_ff));
   assign half   = REM_W'(per_ff >> 1);

   always_comb begin
      busy_in  = busy_ff;
      stale_in = stale_ff;
      rem_in   = rem_ff;
      per_in   = per_ff;
      if (calc_req.start) begin
         busy_in  = 1'b1;
         per_in   = calc_req.period;
         // zero period counts as stale, answer is 0 either way
         stale_in = (calc_req.period == '0) || (calc_req.elapsed > TIME_W'(triple));
         rem_in   = calc_req.elapsed[REM_W-1:0];
      end else if (busy_ff) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            rem_in = rem_ff - REM_W'(per_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      stale_ff <= stale_in;
      rem_ff   <= rem_in;
      per_ff   <= per_in;
   end

   always_comb begin
      calc_rsp.done  = busy_ff && fin;
      calc_rsp.quiet = '0;
      if (!stale_ff && (rem_ff >= half)) begin
         calc_rsp.quiet = QUIET_W'(per_ff - rem_ff[PERIOD_W-1:0]);
      end
   end

endmodule

/* rtl/neighbor_hello_quiet_window.sv */
// hello: a scan of the id/time memory, one entry a cycle, then a write-back;
//   hellos give no result
// query: from accept to result valid, the table scan and then up to three compare-subtract
//   steps of the phase unit
// one item at a time; a finished result waits in the output register while the next item runs
// synchronous active-high reset clears valid flags, control state and sets period to 30000
module neighbor_hello_quiet_window
   import nhqw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nhqw_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nhqw_rsp_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   // config register
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                csr_hit;

   // latched item
   logic              type_ff, type_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // scan counter and trackers
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0] hit_time_ff, hit_time_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [TIME_W-1:0] min_time_ff, min_time_in;

   // valid flags, one per entry
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // id and time memories, registered read
   logic [ID_W-1:0]   id_mem   [TABLE_ENTRIES];
   logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];
   logic [ID_W-1:0]   rd_id_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  eval_idx;

   // phase unit
   nhqw_calc_req_type calc_req;
   nhqw_calc_rsp_type calc_rsp;
   logic [QUIET_W-1:0] quiet_ff, quiet_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   nhqw_rsp_type rsp_data_ff, rsp_data_in;

   logic accept;

   // ------------------------------------------------------------------
   // config port: one register, no wait states
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_HELLO_PERIOD);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(period_ff) : '0;

   always_comb begin
      period_in = period_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         period_in = csr_pwdata[PERIOD_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // memory access: the scan reads entry cnt while entry cnt-1 is judged;
   // the write-back happens after the scan ends and before the next item
   // starts, so reads and writes never overlap on an entry
   // ------------------------------------------------------------------
   assign rd_en    = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(TABLE_ENTRIES));
   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign eval_idx = IDX_W'(cnt_ff - CNT_W'(1));
   assign wr_en    = (state_ff == ST_WRITE);

   // hit refreshes, else lowest free entry, else oldest time
   always_comb begin
      if (hit_ff) begin
         wr_idx = hit_idx_ff;
      end else if (free_ff) begin
         wr_idx = free_idx_ff;
      end else begin
         wr_idx = min_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id_ff   <= id_mem[rd_addr];
         rd_time_ff <= time_mem[rd_addr];
      end
      if (wr_en) begin
         id_mem[wr_idx]   <= id_ff;
         time_mem[wr_idx] <= now_ff;
      end
   end

   // ------------------------------------------------------------------
   // phase unit hookup
   // ------------------------------------------------------------------
   always_comb begin
      calc_req.start   = (state_ff == ST_START);
      calc_req.period  = period_ff;
      calc_req.elapsed = now_ff - hit_time_ff; // wraps mod 2^32
   end

   nhqw_quiet_calc u_calc (
      .clock    (clock),
      .reset    (reset),
      .calc_req (calc_req),
      .calc_rsp (calc_rsp)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_time_in  = hit_time_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      min_idx_in   = min_idx_ff;
      min_time_in  = min_time_ff;
      valid_in     = valid_ff;
      quiet_in     = quiet_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               type_in  = req_data.req_type;
               // only the low ID_BYTES bytes of the id take part
               id_in    = req_data.node_id[ID_W-1:0];
               now_in   = req_data.now_ms;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != '0) begin
               // first match wins
               if (valid_ff[eval_idx] && (rd_id_ff == id_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = eval_idx;
                  hit_time_in = rd_time_ff;
               end
               // lowest-index free entry
               if (!valid_ff[eval_idx] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx;
               end
               // oldest entry, strict compare keeps the lowest index on a tie
               if ((cnt_ff == CNT_W'(1)) || (rd_time_ff < min_time_ff)) begin
                  min_idx_in  = eval_idx;
                  min_time_in = rd_time_ff;
               end
            end
            if (cnt_ff == CNT_W'(TABLE_ENTRIES)) begin
               if (type_ff == REQ_HELLO) begin
                  state_in = ST_WRITE;
               end else if (hit_in) begin
                  state_in = ST_START;
               end else begin
                  // unknown id on a query: no result
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            valid_in[wr_idx] = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (calc_rsp.done) begin
               quiet_in = calc_rsp.quiet;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.quiet_ms = quiet_ff;
               rsp_data_in.known    = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
      type_ff     <= type_in;
      id_ff       <= id_in;
      now_ff      <= now_in;
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_time_ff <= hit_time_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      min_idx_ff  <= min_idx_in;
      min_time_ff <= min_time_in;
      quiet_ff    <= quiet_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/nhqw_checker.sv */
module nhqw_checker
   import nhqw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input nhqw_rsp_type          rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // only known ids produce a result
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.known)
      else $error("result for unknown id");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // a new result only comes out of an item in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without item in work");

endmodule

bind neighbor_hello_quiet_window nhqw_checker u_nhqw_checker (.*);
